FILE: src/cacr_pkg.sv
// Shared types and constants for the cost-aware cache replacement unit.
// Holds the slot record layout, status and register codes, and the log helper.
// No dependencies.
`default_nettype none

package cacr_pkg;

	localparam int KEY_W      = 64;
	localparam int LEN_W      = 24;
	localparam int SIZE_W     = 24;
	localparam int COST_W     = 16;
	localparam int TIME_W     = 32;
	localparam int STATUS_W   = 3;
	localparam int LN_W       = 13;
	localparam int ENTRIES_W  = 10;
	localparam int BUDGET_W   = 32;
	localparam int ITEM_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_STORED   = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_SLOT  = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITEM       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COST       = 2'd3;

	localparam logic [ENTRIES_W-1:0] RST_MAX_ENTRIES = 10'd500;
	localparam logic [BUDGET_W-1:0]  RST_MAX_TOTAL   = 32'd5000000;
	localparam logic [ITEM_W-1:0]    RST_MAX_ITEM    = 24'd1000000;
	localparam logic [COST_W-1:0]    RST_MIN_COST    = 16'd1;

	// ln2 in Q0.16
	localparam logic [16:0] LN2_Q16 = 17'd45426;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] size;
		logic [COST_W-1:0] cost;
		logic [TIME_W-1:0] stamp;
		logic [LN_W-1:0]   lnv;
	} entry_t;

	function automatic logic [4:0] msb_index(input logic [24:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 25; i++) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/cost_aware_cache_replacement_unit.sv
// Top level of the cost-aware cache replacement unit: slot memory and sequencer.
// Depends on cacr_pkg.
`default_nettype none

// Cost-aware replacement table. A command beat is taken when start is high and
// busy is low; exactly one result follows, shown for one cycle with done high.
// The receiver cannot stall, so sample the result in the done cycle. All slot
// records sit in one synchronous memory with a registered read, and every pass
// walks it one slot per cycle. After reset the unit clears every slot of the
// memory with busy high; configuration writes are taken throughout
// (cfg_ready is always high). The work per item is made of those passes:
// a lookup is one pass that ends early at the first hit; a rejected insert
// answers straight from idle; an accepted insert runs the log evaluation, the
// same-key pass, one decision step, a scoring eviction pass with its budget
// check for each scoring eviction, and the free-slot search.
// The log of the stored size plus one is computed once at insert and kept
// with the record, so scoring runs at one slot per cycle.
module cost_aware_cache_replacement_unit #(
	parameter int SLOTS = 512
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    command,
	input  logic [cacr_pkg::KEY_W-1:0]              key,
	input  logic [cacr_pkg::LEN_W-1:0]              length,
	input  logic [cacr_pkg::SIZE_W-1:0]             stored_size,
	input  logic [cacr_pkg::COST_W-1:0]             cost,
	input  logic [cacr_pkg::TIME_W-1:0]             now,
	output logic                                    done,
	output logic [cacr_pkg::STATUS_W-1:0]           status,
	output logic [$clog2(SLOTS)-1:0]                slot,
	output logic [cacr_pkg::SIZE_W-1:0]             found_size,
	output logic [$clog2(SLOTS+1)-1:0]              evictions,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [cacr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [cacr_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import cacr_pkg::*;

	localparam int AW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int UBW = AW + SIZE_W + 1;                 // byte count never wraps
	localparam int BW  = ((UBW > BUDGET_W) ? UBW : BUDGET_W) + 1;
	localparam int EW  = ((AW + 1) > ENTRIES_W) ? (AW + 1) : ENTRIES_W;
	localparam int WW  = TIME_W + 1 + LN_W;               // elapsed * (256 + L)
	localparam int PW  = WW + COST_W;                     // cross product

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LN, S_MATCH, S_DECIDE, S_FREE,
		S_EVSCAN, S_EVDROP, S_CHECK, S_STORE, S_LOOK
	} state_t;

	state_t state_q;

	// configuration
	logic [ENTRIES_W-1:0] max_entries_q;
	logic [BUDGET_W-1:0]  max_total_q;
	logic [ITEM_W-1:0]    max_item_q;
	logic [COST_W-1:0]    min_cost_q;

	// captured command beat
	logic [KEY_W-1:0]  key_q;
	logic [LEN_W-1:0]  len_q;
	logic [SIZE_W-1:0] size_q;
	logic [COST_W-1:0] cost_q;
	logic [TIME_W-1:0] now_q;

	// occupancy
	logic [CW-1:0]  used_count_q;
	logic [UBW-1:0] used_bytes_q;
	logic [CW-1:0]  evict_q;

	// scan engine
	logic [AW:0]   scan_addr_q;
	logic [AW:0]   scan_end_q;
	logic          v_s1;
	logic [AW-1:0] a_s1;
	entry_t        rd_s1;
	logic          v_s2;
	logic [AW-1:0] a_s2;
	logic [WW-1:0] w_s2;
	logic [COST_W-1:0] c_s2;
	logic [SIZE_W-1:0] sz_s2;

	// best eviction candidate
	logic              have_q;
	logic [AW-1:0]     best_a_q;
	logic [WW-1:0]     best_w_q;
	logic [COST_W-1:0] best_c_q;
	logic [SIZE_W-1:0] best_sz_q;

	// log unit
	logic [4:0]    ln_e_q;
	logic [30:0]   ln_m_q;
	logic [15:0]   ln_frac_q;
	logic [4:0]    ln_cnt_q;
	logic [LN_W-1:0] lnv_q;

	logic [AW-1:0] slot_q;

	// result register
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [AW-1:0]       slot_out_q;
	logic [SIZE_W-1:0]   found_q;
	logic [CW-1:0]       evict_out_q;

	// slot memory
	entry_t mem [SLOTS];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;

	logic scan_state, scan_left, rd_en, hit_s1, free_s1, pass_end, ev_end;
	logic cnt_ok, bud_ok, better;
	logic [EW-1:0] lim_w;
	logic [AW:0]   lim;
	logic [BW-1:0] need_bytes;
	logic [TIME_W:0] elapsed_s1;
	logic [LN_W-1:0] lw_s1;
	logic [WW-1:0]   w_s1;
	logic [COST_W-1:0] c_s1;
	logic [PW-1:0] p_new, p_old;
	logic [24:0]   ln_v;
	logic [4:0]    ln_e0;
	logic [54:0]   ln_sh;
	logic [61:0]   ln_sq;
	logic [31:0]   ln_top;
	logic [37:0]   ln_prod;
	logic [37:0]   ln_rnd;
	logic          reject;

	assign cfg_ready  = 1'b1;
	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign slot       = slot_out_q;
	assign found_size = found_q;
	assign evictions  = evict_out_q;

	always_comb begin
		scan_state = (state_q == S_MATCH) || (state_q == S_FREE) ||
		             (state_q == S_EVSCAN) || (state_q == S_LOOK);
		scan_left  = (scan_addr_q != scan_end_q);
		rd_en      = scan_state && scan_left;
		hit_s1     = v_s1 && rd_s1.valid && (rd_s1.key == key_q);
		free_s1    = v_s1 && !rd_s1.valid;
		pass_end   = !scan_left && !v_s1;
		ev_end     = pass_end && !v_s2;

		// limits against current occupancy
		cnt_ok     = (EW'(used_count_q) < EW'(max_entries_q));
		need_bytes = BW'(used_bytes_q) + BW'(len_q);
		bud_ok     = (need_bytes <= BW'(max_total_q));
		lim_w      = (EW'(max_entries_q) > EW'(SLOTS)) ? EW'(SLOTS) : EW'(max_entries_q);
		lim        = lim_w[AW:0];

		// score of the slot just read: elapsed * (256 + L), cost 0 counts as 1
		elapsed_s1 = {1'b0, now_q - rd_s1.stamp} + (TIME_W+1)'(1);
		lw_s1      = LN_W'(256) + rd_s1.lnv;
		w_s1       = WW'(elapsed_s1) * WW'(lw_s1);
		c_s1       = (rd_s1.cost == '0) ? COST_W'(1) : rd_s1.cost;

		// strictly greater score replaces the candidate
		p_new  = PW'(w_s2) * PW'(best_c_q);
		p_old  = PW'(best_w_q) * PW'(c_s2);
		better = !have_q || (p_new > p_old);

		// log2 of size + 1 by repeated squaring of a Q1.30 mantissa
		ln_v   = {1'b0, stored_size} + 25'd1;
		ln_e0  = msb_index(ln_v);
		ln_sh  = {ln_v, 30'b0} >> ln_e0;
		ln_sq  = 62'(ln_m_q) * 62'(ln_m_q);
		ln_top = ln_sq[61:30];
		ln_prod = 38'({ln_e_q, ln_frac_q}) * 38'(LN2_Q16);
		ln_rnd  = ln_prod + 38'(1 << 23);

		reject = (length > max_item_q) || (cost < min_cost_q);
	end

	// memory write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = a_s1;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = scan_addr_q[AW-1:0];
			end
			S_MATCH: begin
				mem_we = hit_s1;                   // drop same-key entry
			end
			S_LOOK: begin
				mem_we          = hit_s1;          // refresh stamp on hit
				mem_wdata       = rd_s1;
				mem_wdata.stamp = now_q;
			end
			S_EVDROP: begin
				mem_we    = 1'b1;
				mem_waddr = best_a_q;
			end
			S_STORE: begin
				mem_we          = (size_q != '0);
				mem_waddr       = slot_q;
				mem_wdata.valid = 1'b1;
				mem_wdata.key   = key_q;
				mem_wdata.size  = size_q;
				mem_wdata.cost  = cost_q;
				mem_wdata.stamp = now_q;
				mem_wdata.lnv   = lnv_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (rd_en)  rd_s1 <= mem[scan_addr_q[AW-1:0]];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= RST_MAX_ENTRIES;
			max_total_q   <= RST_MAX_TOTAL;
			max_item_q    <= RST_MAX_ITEM;
			min_cost_q    <= RST_MIN_COST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAX_ENTRIES: max_entries_q <= cfg_data[ENTRIES_W-1:0];
				REG_MAX_TOTAL:   max_total_q   <= cfg_data[BUDGET_W-1:0];
				REG_MAX_ITEM:    max_item_q    <= cfg_data[ITEM_W-1:0];
				REG_MIN_COST:    min_cost_q    <= cfg_data[COST_W-1:0];
				default:         max_entries_q <= max_entries_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			scan_addr_q  <= '0;
			scan_end_q   <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			have_q       <= 1'b0;
			used_count_q <= '0;
			used_bytes_q <= '0;
			evict_q      <= '0;
			done_q       <= 1'b0;
			status_q     <= STATUS_STORED;
			slot_out_q   <= '0;
			found_q      <= '0;
			evict_out_q  <= '0;
			ln_cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			// advance the read pipeline
			v_s1   <= rd_en;
			a_s1   <= scan_addr_q[AW-1:0];
			if (rd_en) scan_addr_q <= scan_addr_q + (AW+1)'(1);
			v_s2   <= (state_q == S_EVSCAN) && v_s1 && rd_s1.valid;
			a_s2   <= a_s1;
			w_s2   <= w_s1;
			c_s2   <= c_s1;
			sz_s2  <= rd_s1.size;

			unique case (state_q)
				S_CLEAR: begin
					scan_addr_q <= scan_addr_q + (AW+1)'(1);
					if (scan_addr_q == (AW+1)'(SLOTS - 1)) state_q <= S_IDLE;
				end

				S_IDLE: begin
					if (start) begin
						key_q   <= key;
						len_q   <= length;
						size_q  <= stored_size;
						cost_q  <= cost;
						now_q   <= now;
						evict_q <= '0;
						scan_addr_q <= '0;
						scan_end_q  <= (AW+1)'(SLOTS);
						if (command == CMD_LOOKUP) begin
							state_q <= S_LOOK;
						end else if (reject) begin
							done_q      <= 1'b1;
							status_q    <= STATUS_REJECTED;
							slot_out_q  <= '0;
							found_q     <= '0;
							evict_out_q <= '0;
						end else begin
							ln_e_q    <= ln_e0;
							ln_m_q    <= ln_sh[30:0];
							ln_frac_q <= '0;
							ln_cnt_q  <= '0;
							state_q   <= S_LN;
						end
					end
				end

				S_LN: begin
					if (ln_cnt_q == 5'd16) begin
						lnv_q   <= ln_rnd[24+LN_W-1:24];
						state_q <= S_MATCH;
					end else begin
						ln_cnt_q <= ln_cnt_q + 5'd1;
						if (ln_top[31]) begin
							ln_frac_q <= {ln_frac_q[14:0], 1'b1};
							ln_m_q    <= ln_top[31:1];
						end else begin
							ln_frac_q <= {ln_frac_q[14:0], 1'b0};
							ln_m_q    <= ln_top[30:0];
						end
					end
				end

				S_LOOK: begin
					if (hit_s1) begin
						done_q      <= 1'b1;
						status_q    <= STATUS_HIT;
						slot_out_q  <= a_s1;
						found_q     <= rd_s1.size;
						evict_out_q <= '0;
						state_q     <= S_IDLE;
					end else if (pass_end) begin
						done_q      <= 1'b1;
						status_q    <= STATUS_MISS;
						slot_out_q  <= '0;
						found_q     <= '0;
						evict_out_q <= '0;
						state_q     <= S_IDLE;
					end
				end

				S_MATCH: begin
					if (hit_s1) begin
						used_count_q <= used_count_q - CW'(1);
						used_bytes_q <= used_bytes_q - UBW'(rd_s1.size);
						evict_q      <= evict_q + CW'(1);
					end
					if (pass_end) state_q <= S_DECIDE;
				end

				S_DECIDE: begin
					scan_addr_q <= '0;
					if (cnt_ok && bud_ok) begin
						scan_end_q <= lim;
						state_q    <= S_FREE;
					end else begin
						scan_end_q <= (AW+1)'(SLOTS);
						have_q     <= 1'b0;
						state_q    <= S_EVSCAN;
					end
				end

				S_EVSCAN: begin
					if (v_s2 && better) begin
						have_q    <= 1'b1;
						best_a_q  <= a_s2;
						best_w_q  <= w_s2;
						best_c_q  <= c_s2;
						best_sz_q <= sz_s2;
					end
					if (ev_end) state_q <= have_q ? S_EVDROP : S_CHECK;
				end

				S_EVDROP: begin
					used_count_q <= used_count_q - CW'(1);
					used_bytes_q <= used_bytes_q - UBW'(best_sz_q);
					evict_q      <= evict_q + CW'(1);
					state_q      <= S_CHECK;
				end

				S_CHECK: begin
					scan_addr_q <= '0;
					if (bud_ok) begin
						scan_end_q <= lim;
						state_q    <= S_FREE;
					end else if (have_q) begin
						// keep evicting while over budget
						scan_end_q <= (AW+1)'(SLOTS);
						have_q     <= 1'b0;
						state_q    <= S_EVSCAN;
					end else begin
						done_q      <= 1'b1;
						status_q    <= STATUS_NO_SLOT;
						slot_out_q  <= '0;
						found_q     <= '0;
						evict_out_q <= evict_q;
						state_q     <= S_IDLE;
					end
				end

				S_FREE: begin
					if (free_s1) begin
						slot_q  <= a_s1;
						state_q <= S_STORE;
					end else if (pass_end) begin
						done_q      <= 1'b1;
						status_q    <= STATUS_NO_SLOT;
						slot_out_q  <= '0;
						found_q     <= '0;
						evict_out_q <= evict_q;
						state_q     <= S_IDLE;
					end
				end

				S_STORE: begin
					if (size_q != '0) begin
						used_count_q <= used_count_q + CW'(1);
						used_bytes_q <= used_bytes_q + UBW'(size_q);
					end
					done_q      <= 1'b1;
					status_q    <= STATUS_STORED;
					slot_out_q  <= slot_q;
					found_q     <= '0;
					evict_out_q <= evict_q;
					state_q     <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the cost-aware cache replacement unit.
// Drives command beats and register writes, predicts every result in step, and checks them.
// Depends on cacr_pkg and cost_aware_cache_replacement_unit.
`timescale 1ns / 1ps

module testbench;
	import cacr_pkg::*;

	localparam int SLOTS      = 512;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int EVICT_W    = $clog2(SLOTS + 1);
	// Worst single item: a full table evicted one scoring pass at a time;
	// keep a wide margin above that.
	localparam int STALL_LIMIT = 1500000;

	typedef struct {
		logic              command;
		logic [KEY_W-1:0]  key;
		logic [LEN_W-1:0]  length;
		logic [SIZE_W-1:0] stored_size;
		logic [COST_W-1:0] cost;
		logic [TIME_W-1:0] now;
	} request_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [SIZE_W-1:0]   found_size;
		logic [EVICT_W-1:0]  evictions;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic command = CMD_INSERT;
	logic [KEY_W-1:0] key = '0;
	logic [LEN_W-1:0] length = '0;
	logic [SIZE_W-1:0] stored_size = '0;
	logic [COST_W-1:0] cost = '0;
	logic [TIME_W-1:0] now = '0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0] slot;
	logic [SIZE_W-1:0] found_size;
	logic [EVICT_W-1:0] evictions;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	cost_aware_cache_replacement_unit #(.SLOTS(SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .key(key), .length(length), .stored_size(stored_size),
		.cost(cost), .now(now), .done(done), .status(status), .slot(slot),
		.found_size(found_size), .evictions(evictions), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow table of the unit, updated at each accepted beat.
	logic [KEY_W-1:0]  tbl_key   [SLOTS];
	logic              tbl_valid [SLOTS];
	logic [SIZE_W-1:0] tbl_size  [SLOTS];
	logic [COST_W-1:0] tbl_cost  [SLOTS];
	logic [TIME_W-1:0] tbl_stamp [SLOTS];
	int unsigned       tbl_count;
	logic [63:0]       tbl_bytes;

	logic [ENTRIES_W-1:0] lim_entries;
	logic [BUDGET_W-1:0]  lim_total;
	logic [ITEM_W-1:0]    lim_item;
	logic [COST_W-1:0]    lim_cost;

	outcome_t pending_results[$];
	int       error_count = 0;
	int       idle_pct = 0;
	int       quiet_cycles = 0;
	logic [KEY_W-1:0]  key_pool[16];
	logic [TIME_W-1:0] clock_now = '0;

	// Natural log of v in Q5.8 via a log2 found by repeated squaring.
	function automatic logic [31:0] log_q8(input logic [31:0] v);
		int unsigned e;
		logic [15:0] frac;
		logic [63:0] m;
		logic [63:0] l2;
		e = 0;
		frac = '0;
		if (v == 0) v = 1;
		while (e < 31 && (v >> (e + 1)) != 0) e++;
		m = ({32'b0, v} << 30) >> e;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				frac[0] = 1'b1;
				m = m >> 1;
			end
		end
		l2 = (64'(e) << 16) | 64'(frac);
		return 32'((l2 * 64'd45426 + 64'h80_0000) >> 24);
	endfunction

	function automatic logic [63:0] age_weight(input int s, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] gap;
		gap = t - tbl_stamp[s];
		return (64'(gap) + 64'd1) * (64'd256 + 64'(log_q8(32'(tbl_size[s]) + 32'd1)));
	endfunction

	function automatic logic [63:0] cost_floor(input int s);
		return (tbl_cost[s] == 0) ? 64'd1 : 64'(tbl_cost[s]);
	endfunction

	function automatic void release_slot(input int s);
		tbl_valid[s] = 1'b0;
		tbl_bytes -= 64'(tbl_size[s]);
		tbl_count--;
	endfunction

	// Drop the highest-scoring valid entry; the earliest slot wins ties.
	function automatic bit evict_costliest(input logic [TIME_W-1:0] t);
		int best;
		logic [63:0] best_w;
		logic [63:0] w;
		bit have;
		best = 0;
		best_w = '0;
		have = 0;
		for (int s = 0; s < SLOTS; s++) begin
			if (tbl_valid[s]) begin
				w = age_weight(s, t);
				if (!have || w * cost_floor(best) > best_w * cost_floor(s)) begin
					best = s;
					best_w = w;
				end
				have = 1;
			end
		end
		if (have) release_slot(best);
		return have;
	endfunction

	function automatic bit find_free(output int s_out);
		int lim;
		lim = (lim_entries > SLOTS) ? SLOTS : int'(lim_entries);
		s_out = 0;
		for (int s = 0; s < lim; s++) begin
			if (!tbl_valid[s]) begin
				s_out = s;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic outcome_t predict_outcome(input request_t r);
		outcome_t o;
		int fs;
		bit ok;
		o = '{status: STATUS_MISS, slot: '0, found_size: '0, evictions: '0};
		fs = 0;
		if (r.command == CMD_LOOKUP) begin
			for (int s = 0; s < SLOTS; s++) begin
				if (tbl_valid[s] && tbl_key[s] == r.key) begin
					tbl_stamp[s] = r.now;
					o.status = STATUS_HIT;
					o.slot = SLOT_W'(s);
					o.found_size = tbl_size[s];
					break;
				end
			end
		end else if (r.length > lim_item || r.cost < lim_cost) begin
			o.status = STATUS_REJECTED;
		end else begin
			for (int s = 0; s < SLOTS; s++) begin
				if (tbl_valid[s] && tbl_key[s] == r.key) begin
					release_slot(s);
					o.evictions++;
				end
			end
			if (tbl_count < lim_entries && tbl_bytes + 64'(r.length) <= 64'(lim_total)) begin
				ok = find_free(fs);
			end else begin
				if (evict_costliest(r.now)) o.evictions++;
				while (tbl_bytes + 64'(r.length) > 64'(lim_total) && evict_costliest(r.now))
					o.evictions++;
				ok = (tbl_bytes + 64'(r.length) <= 64'(lim_total)) && find_free(fs);
			end
			if (!ok) begin
				o.status = STATUS_NO_SLOT;
			end else begin
				o.status = STATUS_STORED;
				o.slot = SLOT_W'(fs);
				// A zero stored size reports the slot but keeps it free.
				if (r.stored_size != 0) begin
					tbl_valid[fs] = 1'b1;
					tbl_key[fs] = r.key;
					tbl_size[fs] = r.stored_size;
					tbl_cost[fs] = r.cost;
					tbl_stamp[fs] = r.now;
					tbl_count++;
					tbl_bytes += 64'(r.stored_size);
				end
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
		error_count++;
	endtask

	// Check every result strobe against the oldest prediction.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, status", '0, 64'(status));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) report_mismatch("status", want.status, status);
				if (slot !== want.slot) report_mismatch("slot", want.slot, slot);
				if (found_size !== want.found_size)
					report_mismatch("found_size", want.found_size, found_size);
				if (evictions !== want.evictions)
					report_mismatch("evictions", want.evictions, evictions);
			end
		end
	end

	// Watchdog: any accepted beat or result clears the stall count.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (++quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("testbench: errors");
			$finish;
		end
	end

	// Send one command beat; entered and left on a falling edge with start
	// still high, so back-to-back beats never lower and raise it in one step.
	task automatic send_request(input request_t r);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		command = r.command;
		key = r.key;
		length = r.length;
		stored_size = r.stored_size;
		cost = r.cost;
		now = r.now;
		start = 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_outcome(r));
		@(negedge clk);
	endtask

	task automatic send_fields(input logic c, input logic [KEY_W-1:0] k,
			input logic [LEN_W-1:0] l, input logic [SIZE_W-1:0] sz,
			input logic [COST_W-1:0] cs, input logic [TIME_W-1:0] t);
		request_t r;
		r = '{command: c, key: k, length: l, stored_size: sz, cost: cs, now: t};
		send_request(r);
	endtask

	// Hold start low and let the unit drain before touching registers.
	task automatic wait_drained();
		start = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SLOTS + 10) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAX_ENTRIES: lim_entries = val[ENTRIES_W-1:0];
			REG_MAX_TOTAL:   lim_total = val[BUDGET_W-1:0];
			REG_MAX_ITEM:    lim_item = val[ITEM_W-1:0];
			REG_MIN_COST:    lim_cost = val[COST_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_limits(input logic [31:0] ent, input logic [31:0] total,
			input logic [31:0] item, input logic [31:0] mc);
		wait_drained();
		write_register(REG_MAX_ENTRIES, ent);
		write_register(REG_MAX_TOTAL, total);
		write_register(REG_MAX_ITEM, item);
		write_register(REG_MIN_COST, mc);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly pooled keys so lookups hit and inserts replace; the rest is noise.
	function automatic request_t random_request();
		request_t r;
		r.command = ($urandom_range(99) < 35) ? CMD_LOOKUP : CMD_INSERT;
		r.key = ($urandom_range(9) == 0) ? rand64() : key_pool[$urandom_range(15)];
		r.length = ($urandom_range(9) < 7) ? LEN_W'($urandom_range(4000)) : LEN_W'($urandom);
		case ($urandom_range(9))
			0:       r.stored_size = '0;
			1, 2:    r.stored_size = SIZE_W'($urandom);
			default: r.stored_size = SIZE_W'($urandom_range(1, 6000));
		endcase
		r.cost = ($urandom_range(9) == 0) ? COST_W'($urandom_range(3)) : COST_W'($urandom);
		clock_now += TIME_W'($urandom_range(60));
		r.now = ($urandom_range(19) == 0) ? TIME_W'($urandom) : clock_now;
		return r;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) send_request(random_request());
	endtask

	// Reset limits: miss on empty, field extremes, both reject reasons,
	// zero stored size, same-key replacement and a hit refresh.
	task automatic test_directed();
		idle_pct = 22;
		send_fields(CMD_LOOKUP, '0, '0, '0, '0, '0);
		send_fields(CMD_INSERT, '0, '0, 24'd100, 16'd1, '0);
		send_fields(CMD_INSERT, '1, 24'd1000000, '1, '1, '1);
		send_fields(CMD_LOOKUP, '1, '1, '1, '1, 32'd5);
		send_fields(CMD_INSERT, 64'd5, 24'd1000001, 24'd10, 16'd9, 32'd6);
		send_fields(CMD_INSERT, 64'd5, 24'd10, 24'd10, 16'd0, 32'd7);
		send_fields(CMD_INSERT, 64'd6, 24'd10, 24'd0, 16'd7, 32'd8);
		send_fields(CMD_LOOKUP, 64'd6, '0, '0, '0, 32'd9);
		send_fields(CMD_INSERT, 64'd7, 24'd10, 24'd300, 16'd2, 32'd10);
		send_fields(CMD_INSERT, 64'd7, 24'd20, 24'd400, 16'd3, 32'd11);
		send_fields(CMD_LOOKUP, 64'd7, '0, '0, '0, 32'hFFFF_FFF0);
		send_fields(CMD_LOOKUP, '0, '0, '0, '0, 32'd12);
		send_fields(CMD_INSERT, 64'hA5A5_5A5A_F0F0_0F0F, '1, 24'd50, 16'd5, 32'd13);
		send_fields(CMD_INSERT, 64'h5A5A_A5A5_0F0F_F0F0, 24'd999, 24'd60, '1, 32'd14);
		send_fields(CMD_LOOKUP, 64'h5A5A_A5A5_0F0F_F0F0, '0, '0, '0, 32'd15);
	endtask

	// Tiny table and budget: capacity and scoring eviction on many inserts.
	task automatic test_tight_budget();
		apply_limits(8, 20000, 5000, 1);
		idle_pct = 22;
		run_random(120);
	endtask

	// Widest limits with a cost floor; many rejects for cheap objects.
	task automatic test_wide_limits();
		apply_limits(512, 32'hFFFF_FFFF, 24'hFF_FFFF, 100);
		idle_pct = 62;
		run_random(110);
	endtask

	// Narrowest limits: one slot, zero budget, zero item size, top cost floor.
	task automatic test_narrow_limits();
		apply_limits(1, 0, 0, 16'hFFFF);
		idle_pct = 0;
		send_fields(CMD_INSERT, 64'd1, '0, 24'd5, 16'hFFFF, 32'd100);
		send_fields(CMD_INSERT, 64'd2, '0, 24'd5, 16'hFFFE, 32'd101);
		send_fields(CMD_INSERT, 64'd2, 24'd1, 24'd5, 16'hFFFF, 32'd102);
		send_fields(CMD_INSERT, 64'd3, '0, 24'd0, 16'hFFFF, 32'd103);
		send_fields(CMD_LOOKUP, 64'd1, '0, '0, '0, 32'd104);
		run_random(30);
	endtask

	// Moderate limits with back-to-back beats.
	task automatic test_streaming();
		apply_limits(16, 30000, 24'hFF_FFFF, 1);
		idle_pct = 0;
		run_random(90);
	endtask

	initial begin
		for (int s = 0; s < SLOTS; s++) begin
			tbl_valid[s] = 1'b0;
			tbl_key[s] = '0;
			tbl_size[s] = '0;
			tbl_cost[s] = '0;
			tbl_stamp[s] = '0;
		end
		tbl_count = 0;
		tbl_bytes = '0;
		lim_entries = RST_MAX_ENTRIES;
		lim_total = RST_MAX_TOTAL;
		lim_item = RST_MAX_ITEM;
		lim_cost = RST_MIN_COST;
		foreach (key_pool[i]) key_pool[i] = rand64();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_tight_budget();
		test_wide_limits();
		test_narrow_limits();
		test_streaming();

		wait_drained();
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/cacr_pkg.sv
src/cost_aware_cache_replacement_unit.sv
bench/testbench.sv
